@@ hw/rtl/tia_pkg.sv @@
`default_nettype none

package tia_pkg;

   localparam int unsigned DataWidth  = 64;
   localparam int unsigned HalfWidth  = 32;
   localparam int unsigned DivStages  = 64;
   localparam int unsigned ShiftBits  = 6;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_MUL  = 5'd2,
      OP_DIV  = 5'd3,
      OP_MOD  = 5'd4,
      OP_AND  = 5'd5,
      OP_OR   = 5'd6,
      OP_XOR  = 5'd7,
      OP_LAND = 5'd8,
      OP_LOR  = 5'd9,
      OP_EQ   = 5'd10,
      OP_NEQ  = 5'd11,
      OP_LT   = 5'd12,
      OP_GT   = 5'd13,
      OP_LTEQ = 5'd14,
      OP_GTEQ = 5'd15,
      OP_LSH  = 5'd16,
      OP_RSH  = 5'd17,
      OP_REV  = 5'd18,
      OP_NOT  = 5'd19,
      OP_INC  = 5'd20,
      OP_DEC  = 5'd21,
      OP_NEG  = 5'd22
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_TYPE = 2'd1,
      ERR_DIV0 = 2'd2
   } err_type;

   localparam logic [3:0] TYPE_U32 = 4'd6;

   // Divider state: partial remainder, dividend bits shifting out at the top
   // while quotient bits shift in at the bottom, and the divisor.
   typedef struct packed {
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] nq;
      logic [DataWidth-1:0] dvs;
   } div_type;

   // Everything that rides alongside the divider.
   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic                 is_bool;
      err_type              err;
      logic                 is_div;
      logic                 is_mod;
      logic                 neg_q;
      logic                 neg_r;
      logic [2:0]           ta;
   } side_type;

   // Cut a value to the width of its type and extend it back to 64 bits.
   function automatic logic [DataWidth-1:0] fit(input logic [DataWidth-1:0] v,
                                                input logic [2:0] t);
      logic [DataWidth-1:0] r;
      logic                 sgn;
      sgn = ~t[2];
      unique case (t[1:0])
         2'd0:    r = {{56{sgn & v[7]}}, v[7:0]};
         2'd1:    r = {{48{sgn & v[15]}}, v[15:0]};
         2'd2:    r = {{32{sgn & v[31]}}, v[31:0]};
         default: r = v;
      endcase
      return r;
   endfunction

   // One restoring division step: bring down one dividend bit.
   function automatic div_type div_step(input div_type s);
      div_type              r;
      logic [DataWidth:0]   t;
      logic [DataWidth:0]   diff;
      t    = {s.rem, s.nq[DataWidth-1]};
      diff = t - {1'b0, s.dvs};
      r.dvs = s.dvs;
      if (t >= {1'b0, s.dvs}) begin
         r.rem = diff[DataWidth-1:0];
         r.nq  = {s.nq[DataWidth-2:0], 1'b1};
      end else begin
         r.rem = t[DataWidth-1:0];
         r.nq  = {s.nq[DataWidth-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/typed_integer_alu.sv @@
// Typed integer ALU for a bytecode machine.
// Request channel (req_): one word per operation. req_tuser carries the opcode
// and the two operand types, req_tdata the two raw 64-bit operands.
// Response channel (rsp_): one word per request, in order. rsp_tdata is the
// result, extended to 64 bits per A's type; rsp_tuser flags a boolean result
// and carries the error code (type mismatch or division by zero).
// From acceptance to rsp_tvalid a word passes three decode and compute
// stages, one stage per quotient bit of the 64-step restoring divider, and
// the output register. Every operation takes the full depth so results
// stay in order.
// Throughput is one word per cycle; the whole pipeline advances together
// whenever the output register is empty or being taken.
// When the receiver stalls, the pipeline holds and one more request word is
// caught in an input skid register, so req_tready drops once that register
// is full and nothing is lost or repeated.
// Reset is synchronous and active high; it empties the pipeline, the skid
// register and the output register. There is no configuration.
`default_nettype none

module typed_integer_alu
   import tia_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // operand_a[63:0], operand_b[127:64]
   input  wire logic [11:0]  req_tuser,  // op[4:0], type_a[7:5], type_b[11:8]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,  // result[63:0]
   output logic [2:0]        rsp_tuser   // result_is_bool[0], error[2:1]
);

   // Global advance: the output register is free or is being emptied.
   logic advance;
   assign advance = ~rsp_tvalid || rsp_tready;

   // ---------------- Input skid register ----------------
   logic         skid_valid_ff;
   logic [127:0] skid_data_ff;
   logic [11:0]  skid_user_ff;
   logic         req_fire;

   assign req_tready = ~skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= 1'b0;
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
      if (!advance && req_fire) begin
         skid_data_ff <= req_tdata;
         skid_user_ff <= req_tuser;
      end
   end

   logic         in_valid;
   logic [127:0] in_data;
   logic [11:0]  in_user;
   assign in_valid = skid_valid_ff || req_fire;
   assign in_data  = skid_valid_ff ? skid_data_ff : req_tdata;
   assign in_user  = skid_valid_ff ? skid_user_ff : req_tuser;

   // ---------------- Stage A: decode, fit operands, type checks ----------------
   op_type               dec_op;
   logic [2:0]           dec_ta;
   logic [3:0]           dec_tb;
   logic [DataWidth-1:0] dec_a;
   logic [DataWidth-1:0] dec_b;
   err_type              dec_err;
   logic                 dec_shift;

   always_comb begin
      dec_op    = op_type'(in_user[4:0]);
      dec_ta    = in_user[7:5];
      dec_tb    = in_user[11:8];
      dec_shift = (dec_op == OP_LSH) || (dec_op == OP_RSH);
      dec_a     = fit(in_data[63:0], dec_ta);
      dec_b     = dec_shift ? {32'b0, in_data[95:64]} : fit(in_data[127:64], dec_ta);
      priority if (in_user[4:0] > OP_NEG) begin
         dec_err = ERR_TYPE;
      end else if (in_user[4:0] >= OP_REV) begin
         dec_err = ERR_NONE;
      end else if (dec_shift) begin
         dec_err = (dec_tb != TYPE_U32) ? ERR_TYPE : ERR_NONE;
      end else if (dec_tb != {1'b0, dec_ta}) begin
         dec_err = ERR_TYPE;
      end else if ((dec_op == OP_DIV || dec_op == OP_MOD) && dec_b == '0) begin
         dec_err = ERR_DIV0;
      end else begin
         dec_err = ERR_NONE;
      end
   end

   logic                 a_valid_ff;
   op_type               a_op_ff;
   logic [2:0]           a_ta_ff;
   logic [DataWidth-1:0] a_a_ff;
   logic [DataWidth-1:0] a_b_ff;
   err_type              a_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
      if (advance) begin
         a_op_ff  <= dec_op;
         a_ta_ff  <= dec_ta;
         a_a_ff   <= dec_a;
         a_b_ff   <= dec_b;
         a_err_ff <= dec_err;
      end
   end

   // ---------------- Stage B: simple ops, partial products, magnitudes ------
   logic                 b_sgn;
   logic                 b_lt;
   logic                 b_gt;
   logic                 b_big;
   logic [DataWidth-1:0] b_simple_in;
   logic                 b_bool_in;
   logic                 b_na;
   logic                 b_nb;

   always_comb begin
      b_sgn = ~a_ta_ff[2];
      b_lt  = b_sgn ? ($signed(a_a_ff) < $signed(a_b_ff)) : (a_a_ff < a_b_ff);
      b_gt  = b_sgn ? ($signed(a_b_ff) < $signed(a_a_ff)) : (a_b_ff < a_a_ff);
      b_big = |a_b_ff[31:ShiftBits];
      b_na  = b_sgn && a_a_ff[DataWidth-1];
      b_nb  = b_sgn && a_b_ff[DataWidth-1];
      b_bool_in = 1'b0;
      unique case (a_op_ff)
         OP_ADD:  b_simple_in = a_a_ff + a_b_ff;
         OP_SUB:  b_simple_in = a_a_ff - a_b_ff;
         OP_AND:  b_simple_in = a_a_ff & a_b_ff;
         OP_OR:   b_simple_in = a_a_ff | a_b_ff;
         OP_XOR:  b_simple_in = a_a_ff ^ a_b_ff;
         OP_LAND: begin
            b_simple_in = {63'b0, (a_a_ff != '0) && (a_b_ff != '0)};
            b_bool_in   = 1'b1;
         end
         OP_LOR: begin
            b_simple_in = {63'b0, (a_a_ff != '0) || (a_b_ff != '0)};
            b_bool_in   = 1'b1;
         end
         OP_EQ: begin
            b_simple_in = {63'b0, a_a_ff == a_b_ff};
            b_bool_in   = 1'b1;
         end
         OP_NEQ: begin
            b_simple_in = {63'b0, a_a_ff != a_b_ff};
            b_bool_in   = 1'b1;
         end
         OP_LT:   b_simple_in = {63'b0, b_lt};
         OP_GT:   b_simple_in = {63'b0, b_gt};
         OP_LTEQ: b_simple_in = {63'b0, ~b_gt};
         OP_GTEQ: b_simple_in = {63'b0, ~b_lt};
         OP_LSH:  b_simple_in = b_big ? '0 : (a_a_ff << a_b_ff[ShiftBits-1:0]);
         OP_RSH: begin
            if (b_big) begin
               b_simple_in = {DataWidth{b_na}};
            end else if (b_sgn) begin
               b_simple_in = $signed(a_a_ff) >>> a_b_ff[ShiftBits-1:0];
            end else begin
               b_simple_in = a_a_ff >> a_b_ff[ShiftBits-1:0];
            end
         end
         OP_REV:  b_simple_in = ~a_a_ff;
         OP_NOT: begin
            b_simple_in = {63'b0, a_a_ff == '0};
            b_bool_in   = 1'b1;
         end
         OP_INC:  b_simple_in = a_a_ff + 64'd1;
         OP_DEC:  b_simple_in = a_a_ff - 64'd1;
         OP_NEG:  b_simple_in = b_sgn ? (~a_a_ff + 64'd1) : a_a_ff;
         default: b_simple_in = '0;
      endcase
   end

   logic                 b_valid_ff;
   op_type               b_op_ff;
   logic [2:0]           b_ta_ff;
   err_type              b_err_ff;
   logic [DataWidth-1:0] b_simple_ff;
   logic                 b_bool_ff;
   logic [DataWidth-1:0] b_p0_ff;
   logic [HalfWidth-1:0] b_p1_ff;
   logic [HalfWidth-1:0] b_p2_ff;
   logic [DataWidth-1:0] b_ua_ff;
   logic [DataWidth-1:0] b_ub_ff;
   logic                 b_na_ff;
   logic                 b_nb_ff;
   logic [HalfWidth-1:0] b_p1_low;
   logic [HalfWidth-1:0] b_p2_low;

   // Only the low halves of the cross products reach the 64-bit product.
   assign b_p1_low = a_a_ff[HalfWidth-1:0] * a_b_ff[DataWidth-1:HalfWidth];
   assign b_p2_low = a_a_ff[DataWidth-1:HalfWidth] * a_b_ff[HalfWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         b_op_ff     <= a_op_ff;
         b_ta_ff     <= a_ta_ff;
         b_err_ff    <= a_err_ff;
         b_simple_ff <= b_simple_in;
         b_bool_ff   <= b_bool_in && (a_err_ff == ERR_NONE);
         b_p0_ff     <= a_a_ff[HalfWidth-1:0] * a_b_ff[HalfWidth-1:0];
         b_p1_ff     <= b_p1_low;
         b_p2_ff     <= b_p2_low;
         b_ua_ff     <= b_na ? (~a_a_ff + 64'd1) : a_a_ff;
         b_ub_ff     <= b_nb ? (~a_b_ff + 64'd1) : a_b_ff;
         b_na_ff     <= b_na;
         b_nb_ff     <= b_nb;
      end
   end

   // ---------------- Stage C: product sum, result select, divider load -----
   logic [HalfWidth-1:0] c_cross;
   logic [DataWidth-1:0] c_mul;
   side_type             c_side;
   div_type              c_div;

   always_comb begin
      c_cross = b_p1_ff + b_p2_ff;
      c_mul   = b_p0_ff + {c_cross, 32'b0};
      c_side.result  = (b_err_ff != ERR_NONE) ? '0
                     : fit((b_op_ff == OP_MUL) ? c_mul : b_simple_ff, b_ta_ff);
      c_side.is_bool = b_bool_ff;
      c_side.err     = b_err_ff;
      c_side.is_div  = (b_op_ff == OP_DIV);
      c_side.is_mod  = (b_op_ff == OP_MOD);
      c_side.neg_q   = b_na_ff ^ b_nb_ff;
      c_side.neg_r   = b_na_ff;
      c_side.ta      = b_ta_ff;
      c_div.rem      = '0;
      c_div.nq       = b_ua_ff;
      c_div.dvs      = b_ub_ff;
   end

   // ---------------- Divider: one quotient bit per stage ----------------
   logic     dv_valid_ff [0:DivStages];
   div_type  dv_ff       [0:DivStages];
   side_type sd_ff       [0:DivStages];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DivStages; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         dv_valid_ff[0] <= b_valid_ff;
         for (int k = 1; k <= DivStages; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
      end
      if (advance) begin
         dv_ff[0] <= c_div;
         sd_ff[0] <= c_side;
         for (int k = 1; k <= DivStages; k++) begin
            dv_ff[k] <= div_step(dv_ff[k-1]);
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   // ---------------- Final select and output register ----------------
   side_type             f_side;
   logic [DataWidth-1:0] f_q;
   logic [DataWidth-1:0] f_r;
   logic [DataWidth-1:0] f_result;

   always_comb begin
      f_side = sd_ff[DivStages];
      f_q    = dv_ff[DivStages].nq;
      f_r    = dv_ff[DivStages].rem;
      if (f_side.err == ERR_NONE && f_side.is_div) begin
         f_result = fit(f_side.neg_q ? (~f_q + 64'd1) : f_q, f_side.ta);
      end else if (f_side.err == ERR_NONE && f_side.is_mod) begin
         f_result = fit(f_side.neg_r ? (~f_r + 64'd1) : f_r, f_side.ta);
      end else begin
         f_result = f_side.result;
      end
   end

   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_data_ff;
   logic [2:0]           rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid_ff[DivStages];
      end
      if (advance) begin
         rsp_data_ff <= f_result;
         rsp_user_ff <= {f_side.err, f_side.is_bool};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tia_checker.sv @@
`default_nettype none

module tia_checker
   import tia_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata,
   input wire logic [2:0]   rsp_tuser
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // The error code is one of the defined codes.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[2:1] == ERR_NONE || rsp_tuser[2:1] == ERR_TYPE ||
                      rsp_tuser[2:1] == ERR_DIV0))
      else $error("undefined error code");

   // A flagged word carries a zero result and no boolean flag.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] != ERR_NONE |-> rsp_tdata == '0 && !rsp_tuser[0])
      else $error("error word has nonzero payload");

   // A boolean result is zero or one.
   a_bool_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[63:1] == '0)
      else $error("boolean result out of range");

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind typed_integer_alu tia_checker u_tia_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ dv/tb_typed_integer_alu.sv @@
`default_nettype none

// Self-checking bench for the typed integer ALU. A table of directed
// operations runs first, then random operations with random gaps on both
// channels. Every response word is checked against the typed-in response of
// its row or a predictor of the expected result, boolean flag and error code.
module tb_typed_integer_alu;
   import tia_pkg::*;

   // Expected response word.
   typedef struct {
      logic [63:0] result;
      logic        is_bool;
      logic [1:0]  err;
   } alu_resp_type;

   // One directed row; has_exp marks rows whose response is typed in.
   typedef struct {
      logic [4:0]  op;
      logic [2:0]  ta;
      logic [3:0]  tb;
      logic [63:0] a;
      logic [63:0] b;
      bit          has_exp;
      logic [63:0] exp_result;
      logic        exp_bool;
      logic [1:0]  exp_err;
   } alu_row_type;

   localparam int unsigned PipeLatency = 68;
   localparam int unsigned RandomOps   = 1450;
   localparam longint unsigned CycleLimit = 400000;

   // Type codes.
   localparam logic [3:0] T_I8  = 4'd0;
   localparam logic [3:0] T_I16 = 4'd1;
   localparam logic [3:0] T_I32 = 4'd2;
   localparam logic [3:0] T_I64 = 4'd3;
   localparam logic [3:0] T_U8  = 4'd4;
   localparam logic [3:0] T_U16 = 4'd5;
   localparam logic [3:0] T_U64 = 4'd7;
   localparam logic [3:0] T_ANY = 4'd8;
   localparam logic [4:0] OP_BAD = 5'd31;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // operand_a[63:0], operand_b[127:64]
   logic [11:0]  req_tuser;   // op[4:0], type_a[7:5], type_b[11:8]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;   // result[63:0]
   logic [2:0]   rsp_tuser;   // result_is_bool[0], error[2:1]

   alu_resp_type expected_q[$];
   int unsigned  fail_count;
   longint unsigned cycle_count;
   bit           long_hold_req;

   typed_integer_alu u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Cut a raw value to its type's width and extend it to 64 bits.
   function automatic logic [63:0] typed_value(logic [63:0] v, logic [2:0] t);
      logic sgn;
      sgn = !t[2];
      case (t[1:0])
         2'd0: return {{56{sgn & v[7]}}, v[7:0]};
         2'd1: return {{48{sgn & v[15]}}, v[15:0]};
         2'd2: return {{32{sgn & v[31]}}, v[31:0]};
         default: return v;
      endcase
   endfunction

   // Append one expectation at the tail of the queue.
   function automatic void add_expected(alu_resp_type e);
      expected_q = {expected_q, e};
   endfunction

   // Predict the response word for one operation.
   function automatic alu_resp_type alu_predict(logic [4:0] op, logic [2:0] ta,
                                                logic [3:0] tb, logic [63:0] ra,
                                                logic [63:0] rb);
      alu_resp_type rsp;
      logic [63:0] a, b, r, ua, ub;
      logic [31:0] sh;
      bit          sgn, na, nb;
      rsp = '{result: '0, is_bool: 1'b0, err: ERR_NONE};
      sgn = !ta[2];
      a   = typed_value(ra, ta);
      r   = '0;
      if (op > OP_NEG) begin
         rsp.err = ERR_TYPE;
         return rsp;
      end
      // Unary operations ignore B altogether.
      if (op >= OP_REV) begin
         case (op)
            OP_REV: r = ~a;
            OP_NOT: begin
               rsp.result  = (a == 0) ? 64'd1 : 64'd0;
               rsp.is_bool = 1'b1;
               return rsp;
            end
            OP_INC: r = a + 1;
            OP_DEC: r = a - 1;
            default: r = sgn ? -a : a;
         endcase
         rsp.result = typed_value(r, ta);
         return rsp;
      end
      // Shifts take an unsigned 32-bit amount from B.
      if (op == OP_LSH || op == OP_RSH) begin
         if (tb != TYPE_U32) begin
            rsp.err = ERR_TYPE;
            return rsp;
         end
         sh = rb[31:0];
         if (op == OP_LSH)
            r = (sh >= 64) ? 64'd0 : (a << sh);
         else if (sgn && a[63])
            r = (sh >= 64) ? '1 : ~((~a) >> sh);
         else
            r = (sh >= 64) ? 64'd0 : (a >> sh);
         rsp.result = typed_value(r, ta);
         return rsp;
      end
      if (tb != {1'b0, ta}) begin
         rsp.err = ERR_TYPE;
         return rsp;
      end
      b = typed_value(rb, ta);
      rsp.is_bool = (op >= OP_LAND && op <= OP_NEQ);
      case (op)
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: r = a * b;
         OP_DIV, OP_MOD: begin
            // Divide magnitudes, then fix the signs: truncation toward zero.
            na = sgn && a[63];
            nb = sgn && b[63];
            ua = na ? -a : a;
            ub = nb ? -b : b;
            if (ub == 0) begin
               rsp.err = ERR_DIV0;
               return rsp;
            end
            if (op == OP_DIV) begin
               r = ua / ub;
               if (na != nb) r = -r;
            end else begin
               r = ua % ub;
               if (na) r = -r;
            end
         end
         OP_AND:  r = a & b;
         OP_OR:   r = a | b;
         OP_XOR:  r = a ^ b;
         OP_LAND: r = (a != 0 && b != 0);
         OP_LOR:  r = (a != 0 || b != 0);
         OP_EQ:   r = (a == b);
         OP_NEQ:  r = (a != b);
         OP_LT:   r = sgn ? ($signed(a) < $signed(b)) : (a < b);
         OP_GT:   r = sgn ? ($signed(a) > $signed(b)) : (a > b);
         OP_LTEQ: r = sgn ? ($signed(a) <= $signed(b)) : (a <= b);
         default: r = sgn ? ($signed(a) >= $signed(b)) : (a >= b);
      endcase
      rsp.result = rsp.is_bool ? r : typed_value(r, ta);
      return rsp;
   endfunction

   // Offer one request word, after a random gap when gaps is set, and hold it until taken.
   task automatic send_word(logic [4:0] op, logic [2:0] ta, logic [3:0] tb,
                            logic [63:0] a, logic [63:0] b, bit gaps);
      int unsigned gap;
      gap = gaps ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {tb, ta, op};
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random 64-bit value, biased toward small numbers and the edges.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 3));
         2: return '1 - 64'($urandom_range(0, 2));
         3: return 64'(1) << $urandom_range(0, 63);
         4: return {{32{1'b1}}, $urandom};
         default: return 64'($urandom_range(0, 300));
      endcase
   endfunction

   // Sender process: directed table, a pause to drain, then random words.
   initial begin
      alu_row_type  rows[$];
      alu_resp_type exp_rsp;
      logic [4:0]  op;
      logic [2:0]  ta;
      logic [3:0]  tb;
      logic [63:0] opa, opb, shift_amt;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      long_hold_req = 1'b0;
      reset         = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = '{
         '{OP_ADD,  3'd4, T_U8,  64'hFF, 64'h1, 1, 64'h0, 0, ERR_NONE},
         '{OP_ADD,  3'd0, T_I8,  64'h7F, 64'h1, 1, 64'hFFFF_FFFF_FFFF_FF80, 0, ERR_NONE},
         '{OP_SUB,  3'd7, T_U64, 64'h0, 64'h1, 1, '1, 0, ERR_NONE},
         '{OP_MUL,  3'd3, T_I64, '1, '1, 1, 64'h1, 0, ERR_NONE},
         '{OP_DIV,  3'd2, T_I32, 64'h7, 64'h0, 1, 64'h0, 0, ERR_DIV0},
         '{OP_MOD,  3'd6, 4'd6,  64'h7, 64'h1_0000_0000, 1, 64'h0, 0, ERR_DIV0},
         '{OP_DIV,  3'd3, T_I64, 64'h8000_0000_0000_0000, '1, 1,
           64'h8000_0000_0000_0000, 0, ERR_NONE},
         '{OP_MOD,  3'd0, T_I8,  64'h80, 64'hFF, 1, 64'h0, 0, ERR_NONE},
         '{OP_DIV,  3'd1, T_I16, 64'hFFF9, 64'h2, 0, 0, 0, ERR_NONE},
         '{OP_MOD,  3'd1, T_I16, 64'hFFF9, 64'h2, 0, 0, 0, ERR_NONE},
         '{OP_DIV,  3'd7, T_U64, '1, 64'h3, 0, 0, 0, ERR_NONE},
         '{OP_AND,  3'd5, T_U16, 64'hF0F0, 64'hFF00, 0, 0, 0, ERR_NONE},
         '{OP_OR,   3'd1, T_U16, 64'h1, 64'h2, 1, 64'h0, 0, ERR_TYPE},
         '{OP_XOR,  3'd7, T_U64, '1, 64'h5555, 0, 0, 0, ERR_NONE},
         '{OP_LAND, 3'd4, T_U8,  64'h100, 64'h1, 1, 64'h0, 1, ERR_NONE},
         '{OP_LOR,  3'd2, T_I32, 64'h0, 64'h0, 1, 64'h0, 1, ERR_NONE},
         '{OP_EQ,   3'd0, T_ANY, 64'h1, 64'h1, 1, 64'h0, 0, ERR_TYPE},
         '{OP_NEQ,  3'd3, 4'd15, 64'h1, 64'h2, 1, 64'h0, 0, ERR_TYPE},
         '{OP_LT,   3'd0, T_I8,  64'h80, 64'h7F, 1, 64'h1, 0, ERR_NONE},
         '{OP_GT,   3'd4, T_U8,  64'h80, 64'h7F, 1, 64'h1, 0, ERR_NONE},
         '{OP_LTEQ, 3'd2, T_I32, 64'h5, 64'h5, 0, 0, 0, ERR_NONE},
         '{OP_GTEQ, 3'd6, 4'd6,  64'h0, '1, 0, 0, 0, ERR_NONE},
         '{OP_LSH,  3'd3, 4'd6,  64'h1, 64'hFFFF_FFFF_0000_0040, 1, 64'h0, 0, ERR_NONE},
         '{OP_RSH,  3'd0, 4'd6,  64'h80, 64'h64, 1, '1, 0, ERR_NONE},
         '{OP_RSH,  3'd4, T_U8,  64'h80, 64'h1, 1, 64'h0, 0, ERR_TYPE},
         '{OP_REV,  3'd5, T_ANY, 64'h0, 64'h0, 1, 64'hFFFF, 0, ERR_NONE},
         '{OP_NOT,  3'd7, T_ANY, 64'h0, '1, 1, 64'h1, 1, ERR_NONE},
         '{OP_INC,  3'd6, T_ANY, 64'hFFFF_FFFF, 64'h0, 1, 64'h0, 0, ERR_NONE},
         '{OP_DEC,  3'd1, T_ANY, 64'h8000, 64'h0, 1, 64'h7FFF, 0, ERR_NONE},
         '{OP_NEG,  3'd4, T_ANY, 64'h5, 64'h0, 1, 64'h5, 0, ERR_NONE},
         '{OP_NEG,  3'd0, T_ANY, 64'h80, 64'h0, 1, 64'hFFFF_FFFF_FFFF_FF80, 0, ERR_NONE},
         '{OP_BAD,  3'd7, T_U64, '1, '1, 1, 64'h0, 0, ERR_TYPE}
      };
      foreach (rows[i]) begin
         exp_rsp = alu_predict(rows[i].op, rows[i].ta, rows[i].tb, rows[i].a, rows[i].b);
         if (rows[i].has_exp) begin
            // Typed-in rows override the predictor, so the design is checked against hand-computed values.
            exp_rsp.result  = rows[i].exp_result;
            exp_rsp.is_bool = rows[i].exp_bool;
            exp_rsp.err     = rows[i].exp_err;
         end
         add_expected(exp_rsp);
         send_word(rows[i].op, rows[i].ta, rows[i].tb, rows[i].a, rows[i].b, 1'b1);
      end

      // Pause until the pipeline has drained completely.
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);

      for (int n = 0; n < RandomOps; n++) begin
         // Ask the receiver for one long hold while back-to-back words keep coming.
         if (n == 200) long_hold_req = 1'b1;
         op = 5'($urandom_range(0, 31));
         if ($urandom_range(0, 9) != 0) op = 5'($urandom_range(0, 22));
         ta = 3'($urandom_range(0, 7));
         // Mostly matching types so the arithmetic is reached; the rest take a random B type.
         if (op == OP_LSH || op == OP_RSH)
            tb = ($urandom_range(0, 7) != 0) ? TYPE_U32 : 4'($urandom_range(0, 15));
         else
            tb = ($urandom_range(0, 7) != 0) ? {1'b0, ta} : 4'($urandom_range(0, 15));
         opa = pick_operand();
         opb = pick_operand();
         if (op == OP_LSH || op == OP_RSH) begin
            shift_amt = 64'($urandom_range(0, 70));
            opb = ($urandom_range(0, 3) == 0) ? opb : {$urandom, shift_amt[31:0]};
         end
         add_expected(alu_predict(op, ta, tb, opa, opb));
         send_word(op, ta, tb, opa, opb, (n < 200 || n > 400) ? $urandom_range(0, 1) : 1'b0);
      end
      req_tvalid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (PipeLatency + 10) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Receiver process: random stalls, one long hold on request.
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = 300;
         end else begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Response checker: compares each accepted word with the oldest expectation.
   always @(posedge clock) begin
      alu_resp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("response word with no expectation: %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_rsp = expected_q.pop_front();
            if (rsp_tdata !== exp_rsp.result) begin
               $error("result: expected %h, actual %h", exp_rsp.result, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[0] !== exp_rsp.is_bool) begin
               $error("result_is_bool: expected %0d, actual %0d", exp_rsp.is_bool,
                      rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[2:1] !== exp_rsp.err) begin
               $error("error: expected %0d, actual %0d", exp_rsp.err, rsp_tuser[2:1]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      fail_count  = 0;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
